### design/p2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2d_pkg
// Types, codes and constants shared by the plane-to-display conversion unit.
// ----------------------------------------------------------------------------
package p2d_pkg;

  localparam int unsigned P2D_FRAME_PIXELS = 4096;
  localparam int unsigned P2D_CNT_W        = $clog2(P2D_FRAME_PIXELS + 1);
  localparam int unsigned P2D_ADDR_W       = $clog2(P2D_FRAME_PIXELS);

  localparam int unsigned P2D_SAMPLE_W = 32;
  localparam int unsigned P2D_PIXEL_W  = 16;
  localparam int unsigned P2D_DIV_STEPS  = P2D_PIXEL_W;
  localparam int unsigned P2D_STEP_W     = $clog2(P2D_DIV_STEPS);

  localparam logic [7:0]              P2D_BIAS8  = 8'h80;
  localparam logic [15:0]             P2D_BIAS16 = 16'h8000;
  localparam logic [P2D_SAMPLE_W-1:0] P2D_BIAS32 = 32'h8000_0000;

  typedef enum logic [2:0] {
    FMT_U8   = 3'd0,
    FMT_U16  = 3'd1,
    FMT_S8   = 3'd2,
    FMT_S16  = 3'd3,
    FMT_U32N = 3'd4,
    FMT_S32N = 3'd5
  } p2d_fmt_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } p2d_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFFSET,
    ST_SCALE,
    ST_DIVIDE,
    ST_DONE
  } p2d_state_e;

  typedef struct packed {
    logic                    operation;
    logic [P2D_SAMPLE_W-1:0] raw_sample;
    logic                    last_sample;
  } p2d_in_t;

  typedef struct packed {
    logic [P2D_PIXEL_W-1:0] pixel_out;
    logic                   frame_end;
  } p2d_out_t;

  typedef struct packed {
    logic load_pass;
    logic load_frame;
    logic emit_read;
    logic calc_off;
    logic calc_num;
    logic div_step;
    logic emit_finish;
  } p2d_cmd_t;

  typedef struct packed {
    logic [2:0] fmt;
    logic       frame_ok;
    logic       out_free;
  } p2d_sts_t;

endpackage
`default_nettype wire

### design/p2d_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2d_ctrl
// Sequencer: decodes accepted transactions and steps the datapath through
// offset, scale and serial division for each emit of a ready frame.
// ----------------------------------------------------------------------------
module p2d_ctrl import p2d_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_op_i,
  input  wire p2d_sts_t sts_i,
  output logic          in_stall_o,
  output p2d_cmd_t      cmd_o
);

  p2d_state_e            state_q, state_d;
  logic [P2D_STEP_W-1:0] step_q, step_d;
  logic                  accept;
  logic                  emit_go;

  assign in_stall_o = (state_q != ST_IDLE) || !sts_i.out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign emit_go    = accept && (in_op_i == OP_EMIT) && sts_i.frame_ok &&
                      ((sts_i.fmt == FMT_U8)  || (sts_i.fmt == FMT_U16) ||
                       (sts_i.fmt == FMT_S8)  || (sts_i.fmt == FMT_S16) ||
                       (sts_i.fmt == FMT_U32N) || (sts_i.fmt == FMT_S32N));

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (emit_go) begin
          state_d = ST_OFFSET;
        end
      end
      ST_OFFSET: state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        step_d = step_q + P2D_STEP_W'(1);
        if (step_q == P2D_STEP_W'(P2D_DIV_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_op_i == OP_LOAD)) begin
          case (sts_i.fmt) inside
            FMT_U8, FMT_U16, FMT_S8, FMT_S16: cmd_o.load_pass  = 1'b1;
            FMT_U32N, FMT_S32N:               cmd_o.load_frame = 1'b1;
            default:                          cmd_o = '0;
          endcase
        end
        cmd_o.emit_read = emit_go;
      end
      ST_OFFSET: cmd_o.calc_off    = 1'b1;
      ST_SCALE:  cmd_o.calc_num    = 1'b1;
      ST_DIVIDE: cmd_o.div_step    = 1'b1;
      ST_DONE:   cmd_o.emit_finish = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> in_stall_o)
    else $error("input accepted during division");

  a_emit_enters_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_read |=> (state_q == ST_OFFSET))
    else $error("emit did not start the sequence");

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command");

endmodule
`default_nettype wire

### design/p2d_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2d_dp
// Datapath: format register, frame store, min/max tracking, offset and
// scale, radix-2 restoring divider and the output register.
// ----------------------------------------------------------------------------
module p2d_dp import p2d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_wdata_i,
  input  wire p2d_in_t    in_data_i,
  input  wire p2d_cmd_t   cmd_i,
  input  wire logic       out_stall_i,
  output logic            out_valid_o,
  output p2d_out_t        out_data_o,
  output p2d_sts_t        sts_o
);

  logic [2:0]              fmt_q;
  logic [P2D_SAMPLE_W-1:0] min_q, min_d, max_q, max_d;
  logic [P2D_CNT_W-1:0]    cnt_q, cnt_d, idx_q, idx_d;
  logic                    ready_q, ready_d;
  logic                    out_valid_q;
  p2d_out_t                out_q;

  logic [P2D_SAMPLE_W-1:0] mem [P2D_FRAME_PIXELS];
  logic [P2D_SAMPLE_W-1:0] rd_q;
  logic [P2D_SAMPLE_W-1:0] off_q, range_q, rem_q;
  logic                    range_zero_q;
  logic [P2D_PIXEL_W-1:0]  quo_q;

  logic [P2D_SAMPLE_W-1:0] key;
  logic [P2D_CNT_W-1:0]    eff_cnt, idx_inc;
  logic                    has_room, wr_en, last_emit;
  logic [P2D_SAMPLE_W+P2D_PIXEL_W-1:0] num;
  logic [P2D_SAMPLE_W+1:0]             trial;
  logic [P2D_PIXEL_W-1:0]              pass_pix;

  assign key      = in_data_i.raw_sample ^
                    ((fmt_q == FMT_S32N) ? P2D_BIAS32 : '0);
  assign eff_cnt  = ready_q ? '0 : cnt_q;
  assign has_room = eff_cnt < P2D_CNT_W'(P2D_FRAME_PIXELS);
  assign wr_en    = cmd_i.load_frame && has_room;
  assign idx_inc  = idx_q + P2D_CNT_W'(1);
  assign last_emit = idx_inc >= cnt_q;

  assign num   = {off_q, {P2D_PIXEL_W{1'b0}}} - {{P2D_PIXEL_W{1'b0}}, off_q};
  assign trial = {1'b0, rem_q, quo_q[P2D_PIXEL_W-1]} - {2'b00, range_q};

  assign sts_o.fmt      = fmt_q;
  assign sts_o.frame_ok = ready_q && (idx_q < cnt_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  always_comb begin
    case (fmt_q)
      FMT_U8:  pass_pix = {8'h00, in_data_i.raw_sample[7:0]};
      FMT_U16: pass_pix = in_data_i.raw_sample[15:0];
      FMT_S8:  pass_pix = {8'h00, in_data_i.raw_sample[7:0] ^ P2D_BIAS8};
      FMT_S16: pass_pix = in_data_i.raw_sample[15:0] ^ P2D_BIAS16;
      default: pass_pix = '0;
    endcase
  end

  always_comb begin
    min_d   = min_q;
    max_d   = max_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    ready_d = ready_q;
    if (cmd_i.load_frame) begin
      cnt_d   = eff_cnt;
      idx_d   = '0;
      ready_d = in_data_i.last_sample;
      if (ready_q) begin
        min_d = '0;
        max_d = '0;
      end
      if (has_room) begin
        cnt_d = eff_cnt + P2D_CNT_W'(1);
        if (eff_cnt == '0) begin
          min_d = key;
          max_d = key;
        end else begin
          if (key < min_q) min_d = key;
          if (key > max_q) max_d = key;
        end
      end
    end else if (cmd_i.emit_finish) begin
      idx_d = idx_inc;
      if (last_emit) begin
        idx_d   = '0;
        cnt_d   = '0;
        ready_d = 1'b0;
        min_d   = '0;
        max_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= FMT_U8;
      min_q       <= '0;
      max_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) fmt_q <= cfg_wdata_i;
      min_q   <= min_d;
      max_q   <= max_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      ready_q <= ready_d;
      if (cmd_i.load_pass || cmd_i.emit_finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[eff_cnt[P2D_ADDR_W-1:0]] <= key;
    if (cmd_i.emit_read) rd_q <= mem[idx_q[P2D_ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_off) begin
      off_q        <= rd_q - min_q;
      range_q      <= max_q - min_q;
      range_zero_q <= max_q == min_q;
    end
    if (cmd_i.calc_num) begin
      rem_q <= num[P2D_SAMPLE_W+P2D_PIXEL_W-1:P2D_PIXEL_W];
      quo_q <= num[P2D_PIXEL_W-1:0];
    end else if (cmd_i.div_step) begin
      if (!trial[P2D_SAMPLE_W+1]) begin
        rem_q <= trial[P2D_SAMPLE_W-1:0];
      end else begin
        rem_q <= {rem_q[P2D_SAMPLE_W-2:0], quo_q[P2D_PIXEL_W-1]};
      end
      quo_q <= {quo_q[P2D_PIXEL_W-2:0], !trial[P2D_SAMPLE_W+1]};
    end
    if (cmd_i.load_pass) begin
      out_q.pixel_out <= pass_pix;
      out_q.frame_end <= in_data_i.last_sample;
    end else if (cmd_i.emit_finish) begin
      out_q.pixel_out <= range_zero_q ? '0 : quo_q;
      out_q.frame_end <= last_emit;
    end
  end

  a_ready_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (cnt_q != '0) && (idx_q < cnt_q))
    else $error("ready frame with no sample left to emit");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_q <= max_q))
    else $error("running minimum above running maximum");

  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_finish && last_emit) |=> !ready_q && (cnt_q == '0))
    else $error("frame state not cleared after final emit");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= P2D_CNT_W'(P2D_FRAME_PIXELS))
    else $error("loaded count beyond capacity");

endmodule
`default_nettype wire

### design/plane_to_display_u16_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plane_to_display_u16_unit
// Display conversion of image samples with min/max stretch to 16 bits.
// ----------------------------------------------------------------------------
// On a load, 8/16-bit formats register their display value into the output
// stage; 32-bit formats write the 4096-entry frame store and update the
// running min/max. An emit passes from acceptance to a result in the output
// register through the store read, offset and range, the x65535 scale, 16
// steps of the radix-2 restoring divider, then the output write. No
// transaction is accepted while an emit is in flight or while the output
// register holds a stalled result. The frame store needs no clearing after
// reset.
// ----------------------------------------------------------------------------
module plane_to_display_u16_unit import p2d_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire p2d_in_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output p2d_out_t        out_data_o
);

  p2d_cmd_t cmd;
  p2d_sts_t sts;

  p2d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.operation),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  p2d_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

### test/tb_plane_to_display_u16_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_plane_to_display_u16_unit
// Self-checking bench for the plane-to-display conversion unit. A directed
// table covers format extremes, the stretch corner cases and the reserved
// formats. Random frames and pass-through bursts follow. Every accepted
// transaction runs through an in-bench conversion model, and every result is
// compared with the oldest pending value.
// ----------------------------------------------------------------------------
module tb_plane_to_display_u16_unit;
  import p2d_pkg::*;

  localparam logic [2:0]  FMT_RSVD6      = 3'd6;
  localparam logic [2:0]  FMT_RSVD7      = 3'd7;
  localparam logic [63:0] FULL_SCALE     = 64'd65535;
  localparam int unsigned RANDOM_ITEMS   = 1450;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned GAP_MAX        = 12;
  localparam bit          TYPED          = 1'b1;
  localparam bit          PRED           = 1'b0;

  typedef struct {
    logic [2:0] fmt;
    p2d_in_t    item;
    bit         typed;
    bit         has_res;
    p2d_out_t   res;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  p2d_in_t    in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  p2d_out_t   out_data_o;

  // conversion model state
  logic [2:0]              st_fmt;
  logic [P2D_SAMPLE_W-1:0] key_store [P2D_FRAME_PIXELS];
  logic [P2D_SAMPLE_W-1:0] key_min;
  logic [P2D_SAMPLE_W-1:0] key_max;
  int unsigned             keys_loaded;
  int unsigned             next_emit;
  bit                      frame_done;

  p2d_out_t    pending_pixels [$];
  stim_row_t   dir_rows [$];
  int unsigned err_count;
  int unsigned work_items;
  int unsigned send_gap_max;
  int unsigned recv_gap_max;
  bit          long_hold_req;
  int unsigned idle_cycles;

  plane_to_display_u16_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void clear_frame();
    key_min     = '0;
    key_max     = '0;
    keys_loaded = 0;
    next_emit   = 0;
    frame_done  = 1'b0;
  endfunction

  function automatic bit convert_sample(input p2d_in_t item, output p2d_out_t res);
    logic [P2D_SAMPLE_W-1:0] key;
    logic [63:0]             span;
    logic [63:0]             quot;
    bit                      has;
    res = '0;
    has = 1'b0;
    if (item.operation == OP_LOAD) begin
      res.frame_end = item.last_sample;
      if (st_fmt == FMT_U8) begin
        res.pixel_out = {8'h00, item.raw_sample[7:0]};
        has = 1'b1;
      end else if (st_fmt == FMT_U16) begin
        res.pixel_out = item.raw_sample[15:0];
        has = 1'b1;
      end else if (st_fmt == FMT_S8) begin
        res.pixel_out = {8'h00, item.raw_sample[7:0] ^ P2D_BIAS8};
        has = 1'b1;
      end else if (st_fmt == FMT_S16) begin
        res.pixel_out = item.raw_sample[15:0] ^ P2D_BIAS16;
        has = 1'b1;
      end else if (st_fmt == FMT_U32N || st_fmt == FMT_S32N) begin
        key = (st_fmt == FMT_S32N) ? (item.raw_sample ^ P2D_BIAS32) : item.raw_sample;
        if (frame_done) clear_frame();
        if (keys_loaded < P2D_FRAME_PIXELS) begin
          if (keys_loaded == 0) begin
            key_min = key;
            key_max = key;
          end else begin
            if (key < key_min) key_min = key;
            if (key > key_max) key_max = key;
          end
          key_store[keys_loaded] = key;
          keys_loaded++;
        end
        if (item.last_sample) begin
          frame_done = 1'b1;
          next_emit  = 0;
        end
      end
    end else if (st_fmt <= FMT_S32N && frame_done && next_emit < keys_loaded) begin
      key  = key_store[next_emit];
      span = {32'd0, key_max} - {32'd0, key_min};
      if (span == 0 || key < key_min) begin
        quot = '0;
      end else begin
        quot = (({32'd0, key} - {32'd0, key_min}) * FULL_SCALE) / span;
        if (quot > FULL_SCALE) quot = FULL_SCALE;
      end
      res.pixel_out = quot[15:0];
      next_emit++;
      res.frame_end = (next_emit >= keys_loaded);
      if (res.frame_end) clear_frame();
      has = 1'b1;
    end
    return has;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    p2d_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with none pending", 32'(out_data_o), 32'd0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data_o.pixel_out !== want.pixel_out)
          report_mismatch("pixel_out", 32'(out_data_o.pixel_out), 32'(want.pixel_out));
        if (out_data_o.frame_end !== want.frame_end)
          report_mismatch("frame_end", 32'(out_data_o.frame_end), 32'(want.frame_end));
      end
    end
  end

  initial begin : recv_proc
    int unsigned wait_left;
    int unsigned hold_left;
    wait_left   = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) wait_left = $urandom_range(0, recv_gap_max);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input p2d_in_t item, input bit typed, input bit typed_has,
                           input p2d_out_t typed_res);
    int unsigned gap;
    bit          got;
    p2d_out_t    pred;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    work_items++;
    got = convert_sample(item, pred);
    if (typed) begin
      if (typed_has) pending_pixels = {pending_pixels, typed_res};
    end else if (got) begin
      pending_pixels = {pending_pixels, pred};
    end
  endtask

  task automatic send_plain(input logic op, input logic [31:0] raw, input logic last);
    p2d_in_t item;
    item.operation   = op;
    item.raw_sample  = raw;
    item.last_sample = last;
    send_item(item, PRED, 1'b0, '0);
  endtask

  task automatic drain(input int unsigned extra);
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_format(input logic [2:0] fmt);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fmt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    st_fmt = fmt;
  endtask

  function automatic void add_row(input logic [2:0] fmt, input p2d_op_e op,
                                  input logic [31:0] raw, input logic last, input bit typed,
                                  input bit has, input logic [15:0] pix, input logic fe);
    stim_row_t row;
    row.fmt              = fmt;
    row.item.operation   = op;
    row.item.raw_sample  = raw;
    row.item.last_sample = last;
    row.typed            = typed;
    row.has_res          = has;
    row.res.pixel_out    = pix;
    row.res.frame_end    = fe;
    dir_rows = {dir_rows, row};
  endfunction

  function automatic logic [31:0] frame_value(input logic [31:0] base, input logic [31:0] mask);
    int unsigned pick;
    pick = $urandom_range(0, 11);
    if (pick == 0) return 32'h0000_0000;
    if (pick == 1) return 32'hFFFF_FFFF;
    return base ^ ($urandom & mask);
  endfunction

  task automatic send_frame();
    logic [31:0] masks [5];
    logic [31:0] base;
    logic [31:0] mask;
    int unsigned len;
    int unsigned n_emit;
    int unsigned shape;
    logic        last;
    masks  = '{32'h0, 32'h1, 32'hFF, 32'hFFFF, 32'hFFFF_FFFF};
    base   = $urandom;
    mask   = masks[$urandom_range(0, 4)];
    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_plain(OP_EMIT, $urandom, 1'($urandom_range(0, 1)));
      last = (i == len - 1) || ($urandom_range(0, 23) == 0);
      send_plain(OP_LOAD, frame_value(base, mask), last);
    end
    shape  = $urandom_range(0, 7);
    n_emit = (shape == 0) ? $urandom_range(0, len) : (shape == 1) ? len + 2 : len;
    for (int unsigned i = 0; i < n_emit; i++)
      send_plain(OP_EMIT, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic random_phase();
    logic [2:0]  pass_fmts [4];
    logic [2:0]  fmt;
    int unsigned sel;
    int unsigned n;
    pass_fmts    = '{FMT_U8, FMT_U16, FMT_S8, FMT_S16};
    sel          = $urandom_range(0, 15);
    if (sel < 6) fmt = pass_fmts[sel % 4];
    else if (sel < 15) fmt = (sel % 2) ? FMT_S32N : FMT_U32N;
    else fmt = $urandom_range(0, 1) ? FMT_RSVD7 : FMT_RSVD6;
    send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
    recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
    drain(DRAIN_CYCLES);
    write_format(fmt);
    if (fmt == FMT_U32N || fmt == FMT_S32N) begin
      n = $urandom_range(1, 3);
      repeat (n) send_frame();
    end else if (fmt <= FMT_S16) begin
      n = $urandom_range(10, 40);
      repeat (n)
        send_plain(($urandom_range(0, 7) == 0) ? OP_EMIT : OP_LOAD, $urandom,
                   1'($urandom_range(0, 1)));
    end else begin
      n = $urandom_range(3, 8);
      repeat (n)
        send_plain(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stim
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = FMT_U8;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    err_count     = 0;
    work_items    = 0;
    send_gap_max  = GAP_MAX;
    recv_gap_max  = GAP_MAX;
    long_hold_req = 1'b0;
    st_fmt        = FMT_U8;
    clear_frame();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(FMT_U8,    OP_LOAD, 32'hFFFF_FFFF, 1'b1, TYPED, 1'b1, 16'h00FF, 1'b1);
    add_row(FMT_U16,   OP_LOAD, 32'hFFFF_FFFF, 1'b0, TYPED, 1'b1, 16'hFFFF, 1'b0);
    add_row(FMT_U16,   OP_LOAD, 32'h5A5A_A5A5, 1'b1, TYPED, 1'b1, 16'hA5A5, 1'b1);
    add_row(FMT_S8,    OP_LOAD, 32'hFFFF_FF7F, 1'b1, TYPED, 1'b1, 16'h00FF, 1'b1);
    add_row(FMT_S16,   OP_LOAD, 32'h0000_0000, 1'b0, TYPED, 1'b1, 16'h8000, 1'b0);
    add_row(FMT_S16,   OP_LOAD, 32'h0000_FFFF, 1'b1, TYPED, 1'b1, 16'h7FFF, 1'b1);
    add_row(FMT_U32N,  OP_EMIT, 32'h0000_0000, 1'b0, TYPED, 1'b0, 16'h0000, 1'b0);
    add_row(FMT_U32N,  OP_LOAD, 32'h0000_0000, 1'b0, TYPED, 1'b0, 16'h0000, 1'b0);
    add_row(FMT_U32N,  OP_LOAD, 32'hFFFF_FFFF, 1'b1, TYPED, 1'b0, 16'h0000, 1'b0);
    add_row(FMT_U32N,  OP_EMIT, 32'h0000_0000, 1'b0, TYPED, 1'b1, 16'h0000, 1'b0);
    add_row(FMT_U32N,  OP_EMIT, 32'h0000_0000, 1'b0, TYPED, 1'b1, 16'hFFFF, 1'b1);
    add_row(FMT_U32N,  OP_EMIT, 32'h0000_0000, 1'b0, TYPED, 1'b0, 16'h0000, 1'b0);
    add_row(FMT_S32N,  OP_LOAD, 32'h8000_0000, 1'b0, TYPED, 1'b0, 16'h0000, 1'b0);
    add_row(FMT_S32N,  OP_LOAD, 32'h7FFF_FFFF, 1'b0, TYPED, 1'b0, 16'h0000, 1'b0);
    add_row(FMT_S32N,  OP_LOAD, 32'h1234_5678, 1'b1, TYPED, 1'b0, 16'h0000, 1'b0);
    add_row(FMT_S32N,  OP_EMIT, 32'h0000_0000, 1'b0, TYPED, 1'b1, 16'h0000, 1'b0);
    add_row(FMT_S32N,  OP_EMIT, 32'h0000_0000, 1'b0, PRED,  1'b0, 16'h0000, 1'b0);
    add_row(FMT_S32N,  OP_LOAD, 32'h0000_0005, 1'b1, TYPED, 1'b0, 16'h0000, 1'b0);
    add_row(FMT_S32N,  OP_EMIT, 32'h0000_0000, 1'b0, TYPED, 1'b1, 16'h0000, 1'b1);
    add_row(FMT_U32N,  OP_LOAD, 32'h0000_0003, 1'b0, TYPED, 1'b0, 16'h0000, 1'b0);
    add_row(FMT_U32N,  OP_LOAD, 32'h0000_0009, 1'b0, TYPED, 1'b0, 16'h0000, 1'b0);
    add_row(FMT_U32N,  OP_LOAD, 32'h0000_000A, 1'b1, TYPED, 1'b0, 16'h0000, 1'b0);
    add_row(FMT_RSVD6, OP_EMIT, 32'hFFFF_FFFF, 1'b1, TYPED, 1'b0, 16'h0000, 1'b0);
    add_row(FMT_RSVD7, OP_LOAD, 32'hFFFF_FFFF, 1'b1, TYPED, 1'b0, 16'h0000, 1'b0);
    add_row(FMT_U16,   OP_EMIT, 32'h0000_0000, 1'b0, TYPED, 1'b1, 16'h0000, 1'b0);
    add_row(FMT_S8,    OP_EMIT, 32'h0000_0000, 1'b0, PRED,  1'b0, 16'h0000, 1'b0);
    add_row(FMT_U8,    OP_EMIT, 32'h0000_0000, 1'b0, TYPED, 1'b1, 16'hFFFF, 1'b1);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].fmt != st_fmt) begin
        drain(DRAIN_CYCLES);
        write_format(dir_rows[i].fmt);
      end
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].has_res, dir_rows[i].res);
    end

    // back up the output: hold off the receiver while items keep coming
    drain(DRAIN_CYCLES);
    write_format(FMT_S16);
    send_gap_max  = 0;
    long_hold_req = 1'b1;
    repeat (60) send_plain(OP_LOAD, $urandom, 1'($urandom_range(0, 1)));

    // pause the sender until the backlog is gone
    drain(DRAIN_CYCLES);

    while (work_items < RANDOM_ITEMS) random_phase();

    drain(DRAIN_CYCLES);
    if (err_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
design/p2d_pkg.sv
design/p2d_ctrl.sv
design/p2d_dp.sv
design/plane_to_display_u16_unit.sv
test/tb_plane_to_display_u16_unit.sv
